// ----- rtl/core/l2sar_pkg.sv -----
// Shared types and codes for the L2CAP SDU reassembly block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package l2sar_pkg;

    // Operation codes carried in the slave-side tuser.
    localparam logic [1:0] OP_RECV        = 2'd0;
    localparam logic [1:0] OP_READ        = 2'd1;
    localparam logic [1:0] OP_FLUSH_ASM   = 2'd2;
    localparam logic [1:0] OP_FLUSH_OLD   = 2'd3;

    // SAR codes of an I-frame.
    localparam logic [1:0] SAR_UNSEG      = 2'd0;
    localparam logic [1:0] SAR_START      = 2'd1;
    localparam logic [1:0] SAR_END        = 2'd2;
    localparam logic [1:0] SAR_CONT       = 2'd3;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_TOO_BIG     = 2'd1;
    localparam logic [1:0] ST_SEG_ERR     = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDX_MTU          = 1'b0;
    localparam logic CFG_IDX_DROP         = 1'b1;

    localparam logic [15:0] MTU_RESET     = 16'd672;
    localparam int FULL_THRESHOLD_DEF     = 8;
    localparam logic [7:0] PENDING_MAX    = 8'd255;

    // Depth of the queue between front and back.
    localparam int QDEPTH                 = 2;
    localparam int QPTR_W                 = $clog2(QDEPTH);
    localparam int QCNT_W                 = $clog2(QDEPTH + 1);

    // A classified operation as handed from front to back.
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  sar;
        logic [15:0] plen;
        logic [15:0] slen;
        logic        too_big;
        logic        is_start;
    } item_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } qstat_t;

endpackage

`default_nettype wire

// ----- rtl/core/l2sar_front.sv -----
// Front stage: accepts operation words and classifies them.
// Depends on l2sar_pkg for the item type and codes.
`default_nettype none

module l2sar_front
    import l2sar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  in_user,
    input  wire logic [31:0] in_data,
    input  wire logic [15:0] mtu,
    output logic             out_valid,
    input  wire logic        out_ready,
    output item_t            out_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  [1:0] sar_in;

    assign sar_in   = in_user[3:2];
    assign in_ready = !valid_reg || out_ready;

    // The MTU check and the start decode need no assembly state.
    always_comb
    begin
        item_next.op       = in_user[1:0];
        item_next.sar      = sar_in;
        item_next.plen     = in_data[15:0];
        item_next.slen     = in_data[31:16];
        item_next.too_big  = (sar_in == SAR_START) && (in_data[31:16] > mtu);
        item_next.is_start = (sar_in == SAR_START) || (sar_in == SAR_UNSEG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/l2sar_queue.sv -----
// Short queue of classified items between the front and back stages.
// Depends on l2sar_pkg for the item type and queue depth.
`default_nettype none

module l2sar_queue
    import l2sar_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  item_t      push_item,
    input  wire logic  pop,
    output item_t      head_item,
    output qstat_t     stat
);

    item_t             mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item  = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/core/l2sar_back.sv -----
// Back stage: applies classified items to the assembly state and the
// SDU queue count, and holds the result word. Depends on l2sar_pkg.
`default_nettype none

module l2sar_back
    import l2sar_pkg::*;
#(
    parameter int FULL_THRESHOLD = FULL_THRESHOLD_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        can_drop,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_data
);

    localparam logic [7:0] THRESH = 8'(FULL_THRESHOLD);

    logic        valid_reg;
    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic [16:0] acc_reg;
    logic [16:0] acc_next;
    logic [15:0] exp_reg;
    logic [15:0] exp_next;
    logic [7:0]  pend_reg;
    logic [7:0]  pend_next;
    logic        full_reg;
    logic        full_next;
    logic        take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        logic [1:0]  status;
        logic        complete;
        logic [15:0] clen;
        logic        dropped;
        logic        rvalid;
        logic        handled;
        logic [16:0] sum;
        logic [1:0]  drop_status;

        status      = ST_OK;
        complete    = 1'b0;
        clen        = '0;
        dropped     = 1'b0;
        rvalid      = 1'b0;
        handled     = 1'b0;
        acc_next    = acc_reg;
        exp_next    = exp_reg;
        pend_next   = pend_reg;
        full_next   = full_reg;
        sum         = acc_reg + {1'b0, in_item.plen};
        drop_status = can_drop ? ST_OK : ST_SEG_ERR;

        unique case (in_item.op)
            OP_RECV:
            begin
                if (in_item.too_big)
                begin
                    status  = ST_TOO_BIG;
                    handled = 1'b1;
                end
                else if (in_item.is_start)
                begin
                    if (acc_reg != '0)
                    begin
                        dropped = 1'b1;
                        handled = 1'b1;
                    end
                    else
                    begin
                        exp_next = (in_item.sar == SAR_START) ? in_item.slen : in_item.plen;
                        acc_next = {1'b0, in_item.plen};
                    end
                end
                else if (acc_reg == '0)
                begin
                    dropped = 1'b1;
                    handled = 1'b1;
                end
                else
                begin
                    acc_next = sum;
                    if (in_item.sar == SAR_END && sum != {1'b0, exp_reg})
                    begin
                        dropped = 1'b1;
                        handled = 1'b1;
                    end
                end

                // A frame that lands exactly on the announced length
                // completes the SDU; one that passes it is an overrun.
                if (!handled)
                begin
                    if (acc_next == {1'b0, exp_next})
                    begin
                        complete = 1'b1;
                        clen     = exp_next;
                        acc_next = '0;
                        if (pend_reg != PENDING_MAX)
                        begin
                            pend_next = pend_reg + 1'b1;
                        end
                        if (pend_next >= THRESH)
                        begin
                            full_next = 1'b1;
                        end
                    end
                    else if (acc_next > {1'b0, exp_next})
                    begin
                        dropped = 1'b1;
                    end
                end

                if (dropped)
                begin
                    status   = drop_status;
                    acc_next = '0;
                    exp_next = '0;
                end
            end
            OP_READ:
            begin
                if (pend_reg != '0)
                begin
                    pend_next = pend_reg - 1'b1;
                    rvalid    = 1'b1;
                    if (pend_next < THRESH)
                    begin
                        full_next = 1'b0;
                    end
                end
            end
            OP_FLUSH_ASM:
            begin
                dropped  = (acc_reg != '0);
                acc_next = '0;
                exp_next = '0;
            end
            OP_FLUSH_OLD:
            begin
                if (pend_reg != '0)
                begin
                    pend_next = pend_reg - 1'b1;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase

        data_next = {2'b00, pend_next, full_next, rvalid, dropped, clen, complete, status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
            exp_reg   <= '0;
            pend_reg  <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (take)
            begin
                acc_reg  <= acc_next;
                exp_reg  <= exp_next;
                pend_reg <= pend_next;
                full_reg <= full_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/l2sar_queue_sdu_stub_unused.sv -----
// Holds no logic; the completed-SDU count is kept in the back stage.
// Depends on nothing.
`default_nettype none
`default_nettype wire

// ----- rtl/core/l2cap_sdu_reassembly.sv -----
// L2CAP SDU reassembly top level: front classifier, two-word queue, back executor.
// Throughput: one operation word per cycle unless m_tready holds off; words pass the front,
// queue and back registers; the back's state update (one 17-bit add, compare) sets the rate.
// Reset (rst_n, asynchronous, active low) closes any open SDU, clears the SDU count and the
// queue-full flag, empties the pipeline, and sets max_incoming_mtu to 672, can_drop_sdus to 0.
`default_nettype none

module l2cap_sdu_reassembly
    import l2sar_pkg::*;
#(
    parameter int FULL_THRESHOLD = FULL_THRESHOLD_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Operation words.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] payload_length, [31:16] sdu_length_field
    input  wire logic [3:0]  s_tuser,   // [1:0] operation, [3:2] sar
    // Result words.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [1:0] status, [2] sdu_complete,
                                        // [18:3] completed_length, [19] sdu_dropped,
                                        // [20] read_valid, [21] queue_full,
                                        // [29:22] queue_count, [31:30] zero
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic   [15:0] mtu_reg;
    logic          can_drop_reg;

    logic          front_valid;
    logic          front_ready;
    item_t         front_item;
    logic          push;
    logic          pop;
    item_t         head_item;
    qstat_t        qstat;
    logic          back_ready;

    // Configuration is always taken; the user must write it only while the block is idle, unchecked.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg      <= MTU_RESET;
            can_drop_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDX_MTU:  mtu_reg      <= cfg_data;
                CFG_IDX_DROP: can_drop_reg <= cfg_data[0];
                default:      mtu_reg      <= mtu_reg;
            endcase
        end
    end

    // The front decodes SAR and checks the announced length against the MTU,
    // neither of which needs the assembly state.
    l2sar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_user   (s_tuser),
        .in_data   (s_tdata),
        .mtu       (mtu_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    assign front_ready = !qstat.full;
    assign push        = front_valid && front_ready;
    assign pop         = !qstat.empty && back_ready;

    l2sar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (qstat)
    );

    // The back owns the assembly byte count, expected length, SDU count and
    // flow-control flag, and holds the result word until it is taken.
    l2sar_back #(
        .FULL_THRESHOLD (FULL_THRESHOLD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .can_drop  (can_drop_reg),
        .in_valid  (!qstat.empty),
        .in_ready  (back_ready),
        .in_item   (head_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // A completed SDU is never also reported as dropped.
    a_complete_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2] && m_tdata[19]))
        else $error("SDU reported both complete and dropped");

    // Completion always carries an ok status.
    a_complete_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_OK))
        else $error("completed SDU with a non-ok status");

    // The front never pushes into a full queue, and the queue never exceeds its depth.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (qstat.count <= QCNT_W'(QDEPTH)) && !(push && qstat.full))
        else $error("front/back queue overflow");

    // A word only leaves the queue if it was pushed earlier or the queue already held a word.
    a_pop_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> $past(push) || $past(qstat.count != '0))
        else $error("queue popped while it held nothing");

endmodule

`default_nettype wire

// ----- tb/l2cap_sdu_reassembly_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for l2cap_sdu_reassembly: directed table, then random SAR traffic.
// Depends on l2sar_pkg and the l2cap_sdu_reassembly RTL; needs no files at run time.

module l2cap_sdu_reassembly_tb;

    import l2sar_pkg::*;

    localparam int          FULL_LEVEL   = FULL_THRESHOLD_DEF;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    // The result sink holds off once, after this many result words, for this many cycles.
    localparam int unsigned HOLD_AT      = 100;
    localparam int unsigned HOLD_CYCLES  = 300;

    // One result word, declared from the top bit down so that it lines up with m_tdata[29:0].
    typedef struct packed {
        logic [7:0]  count;
        logic        full;
        logic        rd_ok;
        logic        dropped;
        logic [15:0] clen;
        logic        done;
        logic [1:0]  status;
    } sdu_result_t;

    // One row of the directed table. When typed is set, the row carries its own answer.
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  sar;
        logic [15:0] plen;
        logic [15:0] slen;
        logic        typed;
        sdu_result_t want;
    } probe_row_t;

    localparam int PROBE_ROWS = 26;

    // Directed rows run under the reset settings: MTU 672, bad SDUs reported.
    // Columns: op, sar, plen, slen, typed, {count, full, rd_ok, dropped, clen, done, status}.
    localparam probe_row_t PROBES [PROBE_ROWS] = '{
        // Read and both flushes with nothing queued and nothing open do nothing.
        '{OP_READ,      SAR_UNSEG, 16'd0,     16'd0,     1'b1,
          '{8'd0, 1'b0, 1'b0, 1'b0, 16'd0,   1'b0, ST_OK}},
        '{OP_FLUSH_OLD, SAR_END,   16'hFFFF,  16'hFFFF,  1'b1,
          '{8'd0, 1'b0, 1'b0, 1'b0, 16'd0,   1'b0, ST_OK}},
        '{OP_FLUSH_ASM, SAR_CONT,  16'd0,     16'd0,     1'b1,
          '{8'd0, 1'b0, 1'b0, 1'b0, 16'd0,   1'b0, ST_OK}},
        // Continuation and end frames with no SDU open.
        '{OP_RECV,      SAR_CONT,  16'd5,     16'hFFFF,  1'b1,
          '{8'd0, 1'b0, 1'b0, 1'b1, 16'd0,   1'b0, ST_SEG_ERR}},
        '{OP_RECV,      SAR_END,   16'hFFFF,  16'd0,     1'b1,
          '{8'd0, 1'b0, 1'b0, 1'b1, 16'd0,   1'b0, ST_SEG_ERR}},
        // Start frames announcing more than the MTU.
        '{OP_RECV,      SAR_START, 16'd10,    16'd673,   1'b1,
          '{8'd0, 1'b0, 1'b0, 1'b0, 16'd0,   1'b0, ST_TOO_BIG}},
        '{OP_RECV,      SAR_START, 16'hFFFF,  16'hFFFF,  1'b1,
          '{8'd0, 1'b0, 1'b0, 1'b0, 16'd0,   1'b0, ST_TOO_BIG}},
        // An empty unsegmented frame completes an SDU of length zero.
        '{OP_RECV,      SAR_UNSEG, 16'd0,     16'hFFFF,  1'b1,
          '{8'd1, 1'b0, 1'b0, 1'b0, 16'd0,   1'b1, ST_OK}},
        '{OP_RECV,      SAR_UNSEG, 16'd100,   16'd0,     1'b1,
          '{8'd2, 1'b0, 1'b0, 1'b0, 16'd100, 1'b1, ST_OK}},
        // An empty start frame leaves nothing open.
        '{OP_RECV,      SAR_START, 16'd0,     16'd672,   1'b1,
          '{8'd2, 1'b0, 1'b0, 1'b0, 16'd0,   1'b0, ST_OK}},
        // A full-MTU SDU in three segments.
        '{OP_RECV,      SAR_START, 16'd300,   16'd672,   1'b0, '0},
        '{OP_RECV,      SAR_CONT,  16'd300,   16'd0,     1'b0, '0},
        '{OP_RECV,      SAR_END,   16'd72,    16'd0,     1'b1,
          '{8'd3, 1'b0, 1'b0, 1'b0, 16'd672, 1'b1, ST_OK}},
        // Start frames that reach the announced length complete at once.
        '{OP_RECV,      SAR_START, 16'd10,    16'd10,    1'b0, '0},
        '{OP_RECV,      SAR_START, 16'd0,     16'd0,     1'b0, '0},
        // A start frame while an SDU is open.
        '{OP_RECV,      SAR_START, 16'd5,     16'd20,    1'b0, '0},
        '{OP_RECV,      SAR_START, 16'd5,     16'd20,    1'b0, '0},
        // An end frame that comes up short.
        '{OP_RECV,      SAR_START, 16'd5,     16'd20,    1'b0, '0},
        '{OP_RECV,      SAR_END,   16'd3,     16'd0,     1'b0, '0},
        // A continuation that runs past the announced length.
        '{OP_RECV,      SAR_START, 16'd5,     16'd20,    1'b0, '0},
        '{OP_RECV,      SAR_CONT,  16'hFFFF,  16'd0,     1'b0, '0},
        // An unsegmented frame while an SDU is open.
        '{OP_RECV,      SAR_START, 16'd5,     16'd20,    1'b0, '0},
        '{OP_RECV,      SAR_UNSEG, 16'd4,     16'd0,     1'b0, '0},
        // Flushing an open assembly reports the drop.
        '{OP_RECV,      SAR_START, 16'd5,     16'd20,    1'b0, '0},
        '{OP_FLUSH_ASM, SAR_UNSEG, 16'd0,     16'd0,     1'b0, '0},
        // A start frame whose own payload overruns the announced length.
        '{OP_RECV,      SAR_START, 16'hFFFF,  16'd5,     1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [15:0] payload_length, [31:16] sdu_length_field
    logic [3:0]  s_tuser;   // [1:0] operation, [3:2] sar
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [1:0] status, [2] sdu_complete, [18:3] completed_length,
                            // [19] sdu_dropped, [20] read_valid, [21] queue_full,
                            // [29:22] queue_count, [31:30] zero
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Reassembly state as the testbench believes it to be, plus its copy of the registers.
    logic [16:0] asm_bytes;
    logic [15:0] asm_target;
    logic [7:0]  sdus_waiting;
    logic        flow_full;
    logic [15:0] mtu_limit;
    logic        drop_quiet;

    // Results owed by the block, oldest first.
    sdu_result_t sdu_expect [$];

    // The answer typed into the directed row that is on the bus right now.
    logic        word_typed;
    sdu_result_t word_want;

    int unsigned words_sent;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          tx_steady;

    l2cap_sdu_reassembly #(
        .FULL_THRESHOLD (FULL_LEVEL)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Any bad sequence closes the assembly; the status depends on whether drops are silent.
    function automatic logic [1:0] discard_assembly();
        asm_bytes  = '0;
        asm_target = '0;
        return drop_quiet ? ST_OK : ST_SEG_ERR;
    endfunction

    // Applies one operation word to the believed state and returns the result it must produce.
    function automatic sdu_result_t reassemble(input logic [1:0] op, input logic [1:0] sar,
                                               input logic [15:0] plen, input logic [15:0] slen);
        sdu_result_t r;
        logic        handled;
        r       = '0;
        handled = 1'b0;
        case (op)
            OP_RECV:
            begin
                if (sar == SAR_START && slen > mtu_limit)
                begin
                    // Oversized announcement: rejected, but nothing open is disturbed.
                    r.status = ST_TOO_BIG;
                    handled  = 1'b1;
                end
                else if (sar == SAR_START || sar == SAR_UNSEG)
                begin
                    if (asm_bytes != 0)
                    begin
                        r.dropped = 1'b1;
                        r.status  = discard_assembly();
                        handled   = 1'b1;
                    end
                    else
                    begin
                        asm_target = (sar == SAR_START) ? slen : plen;
                        asm_bytes  = {1'b0, plen};
                    end
                end
                else
                begin
                    if (asm_bytes == 0)
                    begin
                        r.dropped = 1'b1;
                        r.status  = discard_assembly();
                        handled   = 1'b1;
                    end
                    else
                    begin
                        asm_bytes = asm_bytes + {1'b0, plen};
                        if (sar == SAR_END && asm_bytes != {1'b0, asm_target})
                        begin
                            r.dropped = 1'b1;
                            r.status  = discard_assembly();
                            handled   = 1'b1;
                        end
                    end
                end
                if (!handled)
                begin
                    if (asm_bytes == {1'b0, asm_target})
                    begin
                        r.done    = 1'b1;
                        r.clen    = asm_target;
                        asm_bytes = '0;
                        if (sdus_waiting != PENDING_MAX)
                            sdus_waiting = sdus_waiting + 8'd1;
                        if (sdus_waiting >= FULL_LEVEL)
                            flow_full = 1'b1;
                    end
                    else if (asm_bytes > {1'b0, asm_target})
                    begin
                        r.dropped = 1'b1;
                        r.status  = discard_assembly();
                    end
                end
            end
            OP_READ:
            begin
                if (sdus_waiting != 0)
                begin
                    sdus_waiting = sdus_waiting - 8'd1;
                    r.rd_ok      = 1'b1;
                    if (sdus_waiting < FULL_LEVEL)
                        flow_full = 1'b0;
                end
            end
            OP_FLUSH_ASM:
            begin
                r.dropped  = (asm_bytes != 0);
                asm_bytes  = '0;
                asm_target = '0;
            end
            default:
            begin
                // Discarding the oldest SDU leaves the flow-control flag alone.
                if (sdus_waiting != 0)
                    sdus_waiting = sdus_waiting - 8'd1;
            end
        endcase
        r.full  = flow_full;
        r.count = sdus_waiting;
        return r;
    endfunction

    // Every operation word taken by the block is predicted at the edge that accepts it.
    always @(posedge clk)
    begin : accept_side
        sdu_result_t predicted;
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted = reassemble(s_tuser[1:0], s_tuser[3:2], s_tdata[15:0], s_tdata[31:16]);
            sdu_expect.push_back(word_typed ? word_want : predicted);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every result word taken from the block is held against the oldest expectation.
    always @(posedge clk)
    begin : result_side
        sdu_result_t want;
        sdu_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[29:0];
            if (sdu_expect.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = sdu_expect.pop_front();
                check_field("status",           want.status,  got.status);
                check_field("sdu_complete",     want.done,    got.done);
                check_field("completed_length", want.clen,    got.clen);
                check_field("sdu_dropped",      want.dropped, got.dropped);
                check_field("read_valid",       want.rd_ok,   got.rd_ok);
                check_field("queue_full",       want.full,    got.full);
                check_field("queue_count",      want.count,   got.count);
                check_field("tdata padding",    0,            m_tdata[31:30]);
            end
        end
    end

    // The result sink inserts a random stall before each word, with calm stretches in between.
    // Once, it stops taking words for a long while so that the block backs up into its input.
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned taken;
        bit          rx_steady;
        taken     = 0;
        rx_steady = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 4);
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, sdu_expect.size());
            $display("l2cap_sdu_reassembly_tb: done, errors");
            $finish;
        end
    end

    // Offers one operation word after a random gap and returns at the edge that accepts it.
    task automatic send_word(input logic [1:0] op, input logic [1:0] sar,
                             input logic [15:0] plen, input logic [15:0] slen,
                             input logic typed, input sdu_result_t want);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= {sar, op};
        s_tdata    <= {slen, plen};
        word_typed <= typed;
        word_want  <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    // Registers change only with the block idle: no word offered and no result outstanding.
    task automatic write_reg(input logic idx, input logic [15:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sdu_expect.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDX_MTU)
            mtu_limit = value;
        else
            drop_quiet = value[0];
    endtask

    // Sends one SDU as a well-formed frame sequence with random sizes and cut points.
    // About one multi-segment sequence in eight is spoiled: the last segment overshoots, goes
    // missing, or is replaced by an assembly flush.
    task automatic send_sdu();
        int unsigned total;
        int unsigned rem;
        int unsigned pl;
        int unsigned segs;
        int unsigned flaw;
        int unsigned pick;
        int unsigned j;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            total = $urandom_range(0, 40);
        else if (pick < 80)
            total = $urandom_range(0, mtu_limit);
        else
            total = $urandom_range(0, 16'hFFFF);
        segs = $urandom_range(1, 4);
        flaw = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
        if ($urandom_range(0, 3) == 0)
            send_word(OP_RECV, SAR_UNSEG, 16'(total), 16'($urandom), 1'b0, '0);
        else if (segs == 1 || total < 2)
            send_word(OP_RECV, SAR_START, 16'(total), 16'(total), 1'b0, '0);
        else
        begin
            pl = $urandom_range(1, total - 1);
            send_word(OP_RECV, SAR_START, 16'(pl), 16'(total), 1'b0, '0);
            rem = total - pl;
            for (j = 2; j < segs && rem > 1; j++)
            begin
                pl = $urandom_range(1, rem - 1);
                send_word(OP_RECV, SAR_CONT, 16'(pl), 16'($urandom), 1'b0, '0);
                rem = rem - pl;
            end
            case (flaw)
                1: send_word(OP_RECV, $urandom_range(0, 1) ? SAR_END : SAR_CONT,
                             16'(rem + 1), 16'($urandom), 1'b0, '0);
                2: ;  // the next start frame will find this SDU still open
                3: send_word(OP_FLUSH_ASM, 2'($urandom), 16'($urandom), 16'($urandom),
                             1'b0, '0);
                default: send_word(OP_RECV, SAR_END, 16'(rem), 16'($urandom), 1'b0, '0);
            endcase
        end
    endtask

    // Mostly frame sequences, with reads, oldest-SDU flushes and raw noise mixed in.
    task automatic send_mix(input int unsigned n);
        int unsigned first;
        int unsigned pick;
        first = words_sent;
        while (words_sent - first < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                send_word(2'($urandom), 2'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
            else if (pick < 26)
                send_word(OP_READ, 2'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
            else if (pick < 30)
                send_word(OP_FLUSH_OLD, 2'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
            else
                send_sdu();
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_IDX_MTU;
        cfg_data   <= '0;
        word_typed <= 1'b0;
        word_want  <= '0;
        asm_bytes    = '0;
        asm_target   = '0;
        sdus_waiting = '0;
        flow_full    = 1'b0;
        mtu_limit    = MTU_RESET;
        drop_quiet   = 1'b0;
        words_sent   = 0;
        mismatches   = 0;
        cycle_count  = 0;
        tx_steady    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset settings.
        for (int i = 0; i < PROBE_ROWS; i++)
            send_word(PROBES[i].op, PROBES[i].sar, PROBES[i].plen, PROBES[i].slen,
                      PROBES[i].typed, PROBES[i].want);

        // Widest MTU with silent drops: no start frame is ever too big.
        write_reg(CFG_IDX_MTU, 16'hFFFF);
        write_reg(CFG_IDX_DROP, 16'd1);
        send_mix(250);

        // Zero MTU with errors reported: only empty starts and unsegmented frames get through.
        write_reg(CFG_IDX_MTU, 16'd0);
        write_reg(CFG_IDX_DROP, 16'd0);
        send_mix(150);

        // Push the SDU count into saturation, then drain it with reads and oldest-SDU flushes
        // so that the flow-control flag rises, sticks, and falls again.
        send_word(OP_FLUSH_ASM, SAR_UNSEG, 16'd0, 16'd0, 1'b0, '0);
        repeat (262)
            send_word(OP_RECV, SAR_UNSEG, 16'($urandom_range(0, 15)), 16'($urandom), 1'b0, '0);
        repeat (262)
            send_word($urandom_range(0, 1) ? OP_READ : OP_FLUSH_OLD, 2'($urandom),
                      16'($urandom), 16'($urandom), 1'b0, '0);

        // Random settings for the last stretch.
        write_reg(CFG_IDX_MTU, 16'($urandom));
        write_reg(CFG_IDX_DROP, 16'($urandom_range(0, 1)));
        send_mix(200);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sdu_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("l2cap_sdu_reassembly_tb: done, clean");
        else
            $display("l2cap_sdu_reassembly_tb: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/l2sar_pkg.sv
rtl/core/l2sar_front.sv
rtl/core/l2sar_queue.sv
rtl/core/l2sar_back.sv
rtl/core/l2sar_queue_sdu_stub_unused.sv
rtl/core/l2cap_sdu_reassembly.sv
tb/l2cap_sdu_reassembly_tb.sv
